[design/iup2x_pkg.sv]
// ----------------------------------------------------------------------------
// iup2x_pkg
// Shared constants, codes and types of the 2x bilinear image upsampler.
// ----------------------------------------------------------------------------
package iup2x_pkg;

  localparam int PIX_W        = 8;
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int OUT_ROW_W    = 13;
  localparam int OUT_COL_W    = 11;

  // line store geometry
  localparam int LS_DEPTH = 1024;
  localparam int LS_AW    = $clog2(LS_DEPTH);
  // width used for column compares, holds both the register and LS_DEPTH
  localparam int EXT_W    = (LS_AW + 1 > CFG_WIDTH_W) ? LS_AW + 1 : CFG_WIDTH_W;

  localparam int MAX_SRC_HEIGHT = 4096;
  localparam int ROW_CNT_W      = 12;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;

  localparam logic [CFG_WIDTH_W-1:0]  SRC_WIDTH_RST  = 11'd384;
  localparam logic [CFG_HEIGHT_W-1:0] SRC_HEIGHT_RST = 13'd256;

  // output sub-row of an item: row 2r-1, 2r, 2r+1
  localparam logic [1:0] SUB_UP   = 2'd0;
  localparam logic [1:0] SUB_MID  = 2'd1;
  localparam logic [1:0] SUB_DOWN = 2'd2;

  // output column slot of an item: 2c-2, 2c-1, 2c, 2c+1
  localparam logic [1:0] COL_PREV_EVEN = 2'd0;
  localparam logic [1:0] COL_PREV_ODD  = 2'd1;
  localparam logic [1:0] COL_CUR_EVEN  = 2'd2;
  localparam logic [1:0] COL_CUR_ODD   = 2'd3;

  // everything the result sequencer needs to know about one item
  typedef struct packed {
    logic [PIX_W-1:0]     pix;
    logic [PIX_W-1:0]     above;
    logic [PIX_W-1:0]     left;
    logic [PIX_W-1:0]     left_above;
    logic [ROW_CNT_W-1:0] row;
    logic [LS_AW-1:0]     col;
    logic                 has_up;
    logic                 has_pair;
    logic                 has_end;
    logic                 has_down;
  } desc_t;

endpackage

[design/image_upsample_2x_bilinear_unit.sv]
// ----------------------------------------------------------------------------
// image_upsample_2x_bilinear_unit
// 2x bilinear upsampler for one 8-bit plane with a single source line store.
// ----------------------------------------------------------------------------
//  channel  dir  handshake                 payload
//  -------  ---  ------------------------  ---------------------------------
//  cfg      in   cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//  in       in   in_valid_i / in_stall_o   pixel_i
//  out      out  out_valid_o / out_stall_i value_o, out_row_o, out_col_o,
//                                          last_o, frame_end_o
//
//  An item is registered in the read stage while the line store is read, then
//  is handed to the result sequencer, whose results leave through the output register.
//  The sequencer issues one result per cycle while the output is not stalled, so an item
//  with k results (0 to 12, four in the interior) holds the sequencer until all k are issued.
//  The next item is read from the line store while the current one drains.
//  Reset clears counters and neighbor pixels; the line store is not cleared.
//  out_stall_i freezes the output register, and back-pressure reaches
//  in_stall_o once the sequencer and the read stage are both occupied.
// ----------------------------------------------------------------------------
module image_upsample_2x_bilinear_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [iup2x_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [iup2x_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [iup2x_pkg::PIX_W-1:0]        pixel_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [iup2x_pkg::PIX_W-1:0]        value_o,
  output logic [iup2x_pkg::OUT_ROW_W-1:0]    out_row_o,
  output logic [iup2x_pkg::OUT_COL_W-1:0]    out_col_o,
  output logic                               last_o,
  output logic                               frame_end_o
);

  iup2x_pkg::desc_t desc;
  logic             desc_valid, desc_ready, desc_lastc, desc_lastr;

  iup2x_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_i      (pixel_i),
    .desc_valid_o (desc_valid),
    .desc_ready_i (desc_ready),
    .desc_o       (desc),
    .desc_lastc_o (desc_lastc),
    .desc_lastr_o (desc_lastr)
  );

  iup2x_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (desc_valid),
    .desc_ready_o (desc_ready),
    .desc_i       (desc),
    .desc_lastc_i (desc_lastc),
    .desc_lastr_i (desc_lastr),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .value_o      (value_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .last_o       (last_o),
    .frame_end_o  (frame_end_o)
  );

endmodule

[design/iup2x_line_ram.sv]
// ----------------------------------------------------------------------------
// iup2x_line_ram
// Simple dual-port line store: one write, one read, registered read data.
// ----------------------------------------------------------------------------
module iup2x_line_ram #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read-before-write on a same-address collision; caller forwards
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/iup2x_front.sv]
// ----------------------------------------------------------------------------
// iup2x_front
// Config registers, position counters, line store access and neighbor
// pixels. Builds one result descriptor per item that gives results.
// ----------------------------------------------------------------------------
module iup2x_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [iup2x_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [iup2x_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [iup2x_pkg::PIX_W-1:0]        pixel_i,
  output logic                               desc_valid_o,
  input  logic                               desc_ready_i,
  output iup2x_pkg::desc_t                   desc_o,
  output logic                               desc_lastc_o,
  output logic                               desc_lastr_o
);

  localparam int EW  = iup2x_pkg::EXT_W;
  localparam int AW  = iup2x_pkg::LS_AW;
  localparam int HW  = iup2x_pkg::CFG_HEIGHT_W;
  localparam int RW  = iup2x_pkg::ROW_CNT_W;
  localparam int PW  = iup2x_pkg::PIX_W;

  logic [iup2x_pkg::CFG_WIDTH_W-1:0] src_width_q;
  logic [HW-1:0]                     src_height_q;
  logic [AW-1:0]                     col_cnt_q, col_cnt_d;
  logic [RW-1:0]                     row_cnt_q, row_cnt_d;

  logic          s1_v_q, s1_v_d;
  logic [PW-1:0] s1_pix_q;
  logic [AW-1:0] s1_col_q;
  logic [RW-1:0] s1_row_q;
  logic          s1_lastc_q, s1_lastr_q;

  logic          fwd_q;
  logic [PW-1:0] fwd_pix_q;
  logic [PW-1:0] left_q, left_above_q;

  logic [EW-1:0] w_ext, w_eff, w_m1, col_ext, c_ext;
  logic [HW-1:0] h_eff, h_m1, row_ext, r_ext;
  logic [AW-1:0] c_cl;
  logic [RW-1:0] r_cl;
  logic          lastc, lastr;
  logic          acc, s1_move, no_res;
  logic [PW-1:0] ram_rdata, above;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= iup2x_pkg::SRC_WIDTH_RST;
      src_height_q <= iup2x_pkg::SRC_HEIGHT_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == iup2x_pkg::REG_SRC_WIDTH) begin
        src_width_q <= cfg_data_i[iup2x_pkg::CFG_WIDTH_W-1:0];
      end
      if (cfg_index_i == iup2x_pkg::REG_SRC_HEIGHT) begin
        src_height_q <= cfg_data_i[HW-1:0];
      end
    end
  end

  // effective size: zero counts as one, saturate at the store depth / max height
  always_comb begin
    w_ext = EW'(src_width_q);
    if (w_ext == '0) begin
      w_eff = EW'(1);
    end else if (w_ext > EW'(iup2x_pkg::LS_DEPTH)) begin
      w_eff = EW'(iup2x_pkg::LS_DEPTH);
    end else begin
      w_eff = w_ext;
    end
    w_m1    = w_eff - EW'(1);
    col_ext = EW'(col_cnt_q);
    c_ext   = (col_ext >= w_eff) ? w_m1 : col_ext;
    c_cl    = c_ext[AW-1:0];
    lastc   = (c_ext == w_m1);

    if (src_height_q == '0) begin
      h_eff = HW'(1);
    end else if (src_height_q > HW'(iup2x_pkg::MAX_SRC_HEIGHT)) begin
      h_eff = HW'(iup2x_pkg::MAX_SRC_HEIGHT);
    end else begin
      h_eff = src_height_q;
    end
    h_m1    = h_eff - HW'(1);
    row_ext = HW'(row_cnt_q);
    r_ext   = (row_ext >= h_eff) ? h_m1 : row_ext;
    r_cl    = r_ext[RW-1:0];
    lastr   = (r_ext == h_m1);
  end

  // first column of a line with more columns still to come gives no result
  assign no_res       = (s1_col_q == '0) && !s1_lastc_q;
  assign s1_move      = s1_v_q && (no_res || desc_ready_i);
  assign in_stall_o   = s1_v_q && !s1_move;
  assign acc          = in_valid_i && !in_stall_o;
  assign s1_v_d       = acc || (s1_v_q && !s1_move);
  assign desc_valid_o = s1_v_q && !no_res;

  always_comb begin
    if (lastc) begin
      col_cnt_d = '0;
      row_cnt_d = lastr ? '0 : r_cl + RW'(1);
    end else begin
      col_cnt_d = c_cl + AW'(1);
      row_cnt_d = r_cl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q       <= 1'b0;
      col_cnt_q    <= '0;
      row_cnt_q    <= '0;
      fwd_q        <= 1'b0;
      left_q       <= '0;
      left_above_q <= '0;
    end else begin
      s1_v_q <= s1_v_d;
      if (acc) begin
        col_cnt_q <= col_cnt_d;
        row_cnt_q <= row_cnt_d;
        // the older item writes this entry at the same edge: bypass it
        fwd_q     <= s1_move && (s1_col_q == c_cl);
      end
      if (s1_move) begin
        left_q       <= s1_pix_q;
        left_above_q <= above;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_pix_q   <= pixel_i;
      s1_col_q   <= c_cl;
      s1_row_q   <= r_cl;
      s1_lastc_q <= lastc;
      s1_lastr_q <= lastr;
      fwd_pix_q  <= s1_pix_q;
    end
  end

  iup2x_line_ram #(
    .DEPTH  (iup2x_pkg::LS_DEPTH),
    .DATA_W (PW)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_move),
    .waddr_i (s1_col_q),
    .wdata_i (s1_pix_q),
    .re_i    (acc),
    .raddr_i (c_cl),
    .rdata_o (ram_rdata)
  );

  assign above = fwd_q ? fwd_pix_q : ram_rdata;

  always_comb begin
    desc_o.pix        = s1_pix_q;
    desc_o.above      = above;
    desc_o.left       = left_q;
    desc_o.left_above = left_above_q;
    desc_o.row        = s1_row_q;
    desc_o.col        = s1_col_q;
    desc_o.has_up     = (s1_row_q != '0);
    desc_o.has_pair   = (s1_col_q != '0);
    desc_o.has_end    = s1_lastc_q;
    desc_o.has_down   = s1_lastr_q;
  end

  assign desc_lastc_o = s1_lastc_q;
  assign desc_lastr_o = s1_lastr_q;

endmodule

[design/iup2x_emit.sv]
// ----------------------------------------------------------------------------
// iup2x_emit
// Result sequencer: walks the sub-rows and column slots of one descriptor
// and issues one result per cycle, unless the output is stalled, through an output register.
// ----------------------------------------------------------------------------
module iup2x_emit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               desc_valid_i,
  output logic                               desc_ready_o,
  input  iup2x_pkg::desc_t                   desc_i,
  input  logic                               desc_lastc_i,
  input  logic                               desc_lastr_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [iup2x_pkg::PIX_W-1:0]        value_o,
  output logic [iup2x_pkg::OUT_ROW_W-1:0]    out_row_o,
  output logic [iup2x_pkg::OUT_COL_W-1:0]    out_col_o,
  output logic                               last_o,
  output logic                               frame_end_o
);

  localparam int PW = iup2x_pkg::PIX_W;
  localparam int RO = iup2x_pkg::OUT_ROW_W;
  localparam int CO = iup2x_pkg::OUT_COL_W;

  iup2x_pkg::desc_t desc_q;
  logic             desc_v_q, desc_v_d;
  logic             frame_q;
  logic [1:0]       sub_q, col_q;

  logic             out_v_q, out_v_d;
  logic [PW-1:0]    value_q;
  logic [RO-1:0]    row_q;
  logic [CO-1:0]    col_out_q;
  logic             last_q, frame_end_q;

  logic             emit, load, col_last, sub_last, slot_last;
  logic [1:0]       first_col;
  logic [PW:0]      sum_lla, sum_ap, sum_lp;
  logic [PW+1:0]    sum4;
  logic [PW-1:0]    val;
  logic [RO-1:0]    row_val;
  logic [CO-1:0]    col_val;

  assign emit      = desc_v_q && (!out_v_q || !out_stall_i);
  assign col_last  = (col_q == iup2x_pkg::COL_CUR_ODD) ||
                     ((col_q == iup2x_pkg::COL_PREV_ODD) && !desc_q.has_end);
  assign sub_last  = (sub_q == iup2x_pkg::SUB_DOWN) ||
                     ((sub_q == iup2x_pkg::SUB_MID) && !desc_q.has_down);
  assign slot_last = col_last && sub_last;
  assign first_col = desc_q.has_pair ? iup2x_pkg::COL_PREV_EVEN : iup2x_pkg::COL_CUR_EVEN;

  assign desc_ready_o = !desc_v_q || (emit && slot_last);
  assign load         = desc_valid_i && desc_ready_o;
  assign desc_v_d     = load || (desc_v_q && !(emit && slot_last));
  assign out_v_d      = emit || (out_v_q && out_stall_i);

  // rounded averages
  always_comb begin
    sum_lla = {1'b0, desc_q.left_above} + {1'b0, desc_q.left} + (PW+1)'(1);
    sum_ap  = {1'b0, desc_q.above} + {1'b0, desc_q.pix} + (PW+1)'(1);
    sum_lp  = {1'b0, desc_q.left} + {1'b0, desc_q.pix} + (PW+1)'(1);
    sum4    = (PW+2)'(desc_q.left_above) + (PW+2)'(desc_q.above) +
              (PW+2)'(desc_q.left) + (PW+2)'(desc_q.pix) + (PW+2)'(2);
  end

  always_comb begin
    unique case (col_q)
      iup2x_pkg::COL_PREV_EVEN:
        val = (sub_q == iup2x_pkg::SUB_UP) ? sum_lla[PW:1] : desc_q.left;
      iup2x_pkg::COL_PREV_ODD:
        val = (sub_q == iup2x_pkg::SUB_UP) ? sum4[PW+1:2] : sum_lp[PW:1];
      default:
        val = (sub_q == iup2x_pkg::SUB_UP) ? sum_ap[PW:1] : desc_q.pix;
    endcase
  end

  // row 2r + sub - 1, column 2c + slot - 2
  assign row_val = RO'({desc_q.row, 1'b0}) + RO'(sub_q) - RO'(1);
  assign col_val = CO'({desc_q.col, 1'b0}) + CO'(col_q) - CO'(2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      sub_q    <= iup2x_pkg::SUB_MID;
      col_q    <= iup2x_pkg::COL_CUR_EVEN;
    end else begin
      desc_v_q <= desc_v_d;
      out_v_q  <= out_v_d;
      if (load) begin
        sub_q <= desc_i.has_up ? iup2x_pkg::SUB_UP : iup2x_pkg::SUB_MID;
        col_q <= desc_i.has_pair ? iup2x_pkg::COL_PREV_EVEN : iup2x_pkg::COL_CUR_EVEN;
      end else if (emit) begin
        if (col_last) begin
          sub_q <= sub_q + 2'd1;
          col_q <= first_col;
        end else begin
          col_q <= col_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      desc_q  <= desc_i;
      frame_q <= desc_lastc_i && desc_lastr_i;
    end
    if (emit) begin
      value_q     <= val;
      row_q       <= row_val;
      col_out_q   <= col_val;
      last_q      <= slot_last;
      frame_end_q <= slot_last && frame_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign value_o     = value_q;
  assign out_row_o   = row_q;
  assign out_col_o   = col_out_q;
  assign last_o      = last_q;
  assign frame_end_o = frame_end_q;

endmodule

[design/iup2x_checker.sv]
// ----------------------------------------------------------------------------
// iup2x_checker
// Port-level checks on the result channel of the upsampler.
// ----------------------------------------------------------------------------
module iup2x_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               out_valid_o,
  input  logic                               out_stall_i,
  input  logic [iup2x_pkg::PIX_W-1:0]        value_o,
  input  logic [iup2x_pkg::OUT_ROW_W-1:0]    out_row_o,
  input  logic [iup2x_pkg::OUT_COL_W-1:0]    out_col_o,
  input  logic                               last_o,
  input  logic                               frame_end_o
);

  // a stalled item stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(value_o) && $stable(out_row_o) &&
      $stable(out_col_o) && $stable(last_o) && $stable(frame_end_o))
    else $error("stalled result changed");

  // frame end is always the closing result of its item
  a_frame_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> last_o)
    else $error("frame_end without last");

  // results come in column pairs, so an item always closes on an odd column
  a_last_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> out_col_o[0])
    else $error("item closed on an even column");

endmodule

bind image_upsample_2x_bilinear_unit iup2x_checker u_iup2x_checker (.*);

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 2x bilinear upsampler. A behavioral predictor
// keeps its own line store, neighbor pixels and position counters, turns each
// accepted source pixel into the expected output pixels, and the monitor
// matches every accepted output item in order. Random gaps and stalls on both
// sides, one long output hold, and size changes between phases.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int PIX_W          = iup2x_pkg::PIX_W;
  localparam int OUT_ROW_W      = iup2x_pkg::OUT_ROW_W;
  localparam int OUT_COL_W      = iup2x_pkg::OUT_COL_W;
  localparam int CFG_IDX_W      = iup2x_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W     = iup2x_pkg::CFG_DATA_W;
  localparam int CFG_WIDTH_W    = iup2x_pkg::CFG_WIDTH_W;
  localparam int CFG_HEIGHT_W   = iup2x_pkg::CFG_HEIGHT_W;
  localparam int LS_DEPTH       = iup2x_pkg::LS_DEPTH;
  localparam int MAX_SRC_HEIGHT = iup2x_pkg::MAX_SRC_HEIGHT;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int LONG_HOLD      = 300;
  localparam int RANDOM_ITEMS   = 360;
  localparam int DIRECTED_N     = 19;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam logic [DIRECTED_N*PIX_W-1:0] DIRECTED_PIX = {
    8'h00, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'hFE,
    8'hFF, 8'h00, 8'hAA,
    8'h55, 8'hFF, 8'h00,
    8'hFF, 8'h00, 8'hFF, 8'h01, 8'hFE, 8'h80, 8'h7F
  };

  typedef struct packed {
    logic [PIX_W-1:0]     value;
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
    logic                 last;
    logic                 frame_end;
  } out_pel_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic [PIX_W-1:0]      pixel     = '0;
  logic                  out_stall = 1'b0;
  logic                  cfg_ready;
  logic                  in_stall;
  logic                  out_valid;
  logic [PIX_W-1:0]      value;
  logic [OUT_ROW_W-1:0]  out_row;
  logic [OUT_COL_W-1:0]  out_col;
  logic                  last;
  logic                  frame_end;

  // predictor state
  logic [PIX_W-1:0]        line_mem [LS_DEPTH];
  logic [PIX_W-1:0]        left_pix       = '0;
  logic [PIX_W-1:0]        left_above_pix = '0;
  int unsigned             col_cnt        = 0;
  int unsigned             row_cnt        = 0;
  logic [CFG_WIDTH_W-1:0]  width_reg      = iup2x_pkg::SRC_WIDTH_RST;
  logic [CFG_HEIGHT_W-1:0] height_reg     = iup2x_pkg::SRC_HEIGHT_RST;
  out_pel_t                stage [12];
  int unsigned             stage_n;

  logic [PIX_W-1:0] pixel_feed [$];
  out_pel_t         pending_pels [$];

  int unsigned mismatches     = 0;
  int unsigned idle_cycles    = 0;
  int unsigned tx_gap_left    = 0;
  int unsigned rx_hold_left   = 0;
  int unsigned random_items   = 0;
  bit          tx_quiet       = 1'b0;
  bit          rx_quiet       = 1'b0;
  bit          long_hold_go   = 1'b0;
  bit          long_hold_done = 1'b0;

  image_upsample_2x_bilinear_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .pixel_i     (pixel),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .value_o     (value),
    .out_row_o   (out_row),
    .out_col_o   (out_col),
    .last_o      (last),
    .frame_end_o (frame_end)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned eff_width(logic [CFG_WIDTH_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > LS_DEPTH) return LS_DEPTH;
    return 32'(raw);
  endfunction

  function automatic int unsigned eff_height(logic [CFG_HEIGHT_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_SRC_HEIGHT) return MAX_SRC_HEIGHT;
    return 32'(raw);
  endfunction

  // mostly zero, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int unsigned pick_dim(int unsigned big_lo, int unsigned big_hi);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return $urandom_range(0, 1);
    if (roll < 80) return $urandom_range(2, 6);
    if (roll < 94) return $urandom_range(7, 16);
    return $urandom_range(big_lo, big_hi);
  endfunction

  task automatic stage_pel(int unsigned v, int unsigned orow, int unsigned ocol);
    stage[stage_n] = '{value: v[PIX_W-1:0], row: orow[OUT_ROW_W-1:0],
                       col: ocol[OUT_COL_W-1:0], last: 1'b0, frame_end: 1'b0};
    stage_n++;
  endtask

  // one output row's share of an item: the pair left of the current column,
  // plus the current column pair when it is the last source column
  task automatic emit_row(int unsigned orow, int unsigned c, bit lastc, bit odd,
                          int unsigned p, int unsigned above);
    int unsigned l, la, v0, v1, v;
    l  = 32'(left_pix);
    la = 32'(left_above_pix);
    if (c >= 1) begin
      if (odd) begin
        v0 = (la + l + 1) >> 1;
        v1 = (la + above + l + p + 2) >> 2;
      end else begin
        v0 = l;
        v1 = (l + p + 1) >> 1;
      end
      stage_pel(v0, orow, 2 * c - 2);
      stage_pel(v1, orow, 2 * c - 1);
    end
    if (lastc) begin
      v = odd ? (above + p + 1) >> 1 : p;
      stage_pel(v, orow, 2 * c);
      stage_pel(v, orow, 2 * c + 1);
    end
  endtask

  task automatic interpolate_pixel(logic [PIX_W-1:0] pix);
    int unsigned w, h, c, r, p, above, i;
    bit lastc, lastr;
    w = eff_width(width_reg);
    h = eff_height(height_reg);
    // a position past a shrunk size closes the line or frame
    c = (col_cnt >= w) ? w - 1 : col_cnt;
    r = (row_cnt >= h) ? h - 1 : row_cnt;
    lastc = (c == w - 1);
    lastr = (r == h - 1);
    p = 32'(pix);
    above = 32'(line_mem[c]);
    stage_n = 0;
    if (r >= 1) emit_row(2 * r - 1, c, lastc, 1'b1, p, above);
    emit_row(2 * r, c, lastc, 1'b0, p, above);
    if (lastr) emit_row(2 * r + 1, c, lastc, 1'b0, p, above);
    if (stage_n > 0) begin
      stage[stage_n-1].last      = 1'b1;
      stage[stage_n-1].frame_end = lastr && lastc;
    end
    for (i = 0; i < stage_n; i++) pending_pels.push_back(stage[i]);
    left_above_pix = above[PIX_W-1:0];
    line_mem[c]    = pix;
    left_pix       = pix;
    if (lastc) begin
      col_cnt = 0;
      row_cnt = lastr ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
      row_cnt = r;
    end
  endtask

  task automatic report_mismatch(string field, int unsigned got, int unsigned exp_v,
                                 int unsigned orow, int unsigned ocol);
    mismatches++;
    $display("%0t: %s mismatch at out (%0d,%0d): got %0d, expected %0d",
             $time, field, orow, ocol, got, exp_v);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) interpolate_pixel(pixel);
      if (!in_valid || !in_stall) begin
        if (tx_gap_left > 0) begin
          tx_gap_left--;
          in_valid <= 1'b0;
        end else if (pixel_feed.size() > 0) begin
          in_valid    <= 1'b1;
          pixel       <= pixel_feed.pop_front();
          tx_gap_left = tx_quiet ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    out_pel_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_pels.size() == 0) begin
          report_mismatch("unexpected item", 32'(value), 0, 32'(out_row), 32'(out_col));
        end else begin
          want = pending_pels.pop_front();
          if (value !== want.value)
            report_mismatch("value", 32'(value), 32'(want.value),
                            32'(want.row), 32'(want.col));
          if (out_row !== want.row)
            report_mismatch("out_row", 32'(out_row), 32'(want.row),
                            32'(want.row), 32'(want.col));
          if (out_col !== want.col)
            report_mismatch("out_col", 32'(out_col), 32'(want.col),
                            32'(want.row), 32'(want.col));
          if (last !== want.last)
            report_mismatch("last", 32'(last), 32'(want.last),
                            32'(want.row), 32'(want.col));
          if (frame_end !== want.frame_end)
            report_mismatch("frame_end", 32'(frame_end), 32'(want.frame_end),
                            32'(want.row), 32'(want.col));
        end
      end
      if (rx_hold_left == 0) begin
        if (long_hold_go && !long_hold_done) begin
          rx_hold_left   = LONG_HOLD;
          long_hold_done = 1'b1;
        end else if (!rx_quiet) begin
          rx_hold_left = pick_gap();
        end
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (pixel_feed.size() != 0 || in_valid || pending_pels.size() != 0);
    // an item with no output may still be in flight
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk);
    while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    if (idx == iup2x_pkg::REG_SRC_WIDTH) width_reg = data[CFG_WIDTH_W-1:0];
    else if (idx == iup2x_pkg::REG_SRC_HEIGHT) height_reg = data;
    @(negedge clk);
  endtask

  task automatic feed_list(int unsigned first, int unsigned n);
    int unsigned i;
    @(negedge clk);
    for (i = first; i < first + n; i++)
      pixel_feed.push_back(DIRECTED_PIX[(DIRECTED_N - 1 - i) * PIX_W +: PIX_W]);
  endtask

  task automatic feed_random(int unsigned n);
    int unsigned i, roll;
    @(negedge clk);
    for (i = 0; i < n; i++) begin
      roll = $urandom_range(0, 9);
      if (roll == 0) pixel_feed.push_back(8'h00);
      else if (roll == 1) pixel_feed.push_back(8'hFF);
      else pixel_feed.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    int unsigned w_new, h_new, w, h, frame, count, rc, cc, phase;
    logic [1:0] spare_bits;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset sizes, first line only, pixel extremes
    feed_list(0, 6);
    wait_drained();
    // zero sizes act as 1x1, written mid-line
    cfg_write(iup2x_pkg::REG_SRC_WIDTH, 13'd0);
    cfg_write(iup2x_pkg::REG_SRC_HEIGHT, 13'd0);
    feed_list(6, 3);
    wait_drained();
    // oversized registers saturate
    cfg_write(iup2x_pkg::REG_SRC_WIDTH, 13'd2047);
    cfg_write(iup2x_pkg::REG_SRC_HEIGHT, 13'd8191);
    feed_list(9, 3);
    wait_drained();
    // shrink below the current column, then finish a 3x3 frame
    cfg_write(iup2x_pkg::REG_SRC_WIDTH, 13'd3);
    cfg_write(iup2x_pkg::REG_SRC_HEIGHT, 13'd3);
    feed_list(12, 7);
    wait_drained();
    cfg_write(REG_SPARE_A, 13'h1FFF);
    cfg_write(REG_SPARE_B, 13'h0AAA);

    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      tx_quiet = ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
      if (phase == 0) begin
        // sender flat out against a long output hold
        tx_quiet     = 1'b1;
        rx_quiet     = 1'b0;
        long_hold_go = 1'b1;
        w_new = 4;
        h_new = 4;
      end else begin
        w_new = pick_dim(17, 48);
        h_new = pick_dim(4097, 8191);
      end
      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        // widen only at the top of a frame: columns past the old width have
        // no valid line above them yet
        if (row_cnt != 0 && eff_width(w_new[CFG_WIDTH_W-1:0]) > eff_width(width_reg))
          w_new = eff_width(width_reg);
        spare_bits = 2'($urandom_range(0, 3));
        if (phase == 0 || $urandom_range(0, 4) != 0)
          cfg_write(iup2x_pkg::REG_SRC_WIDTH, {spare_bits, w_new[CFG_WIDTH_W-1:0]});
        cfg_write(iup2x_pkg::REG_SRC_HEIGHT, h_new[CFG_HEIGHT_W-1:0]);
      end

      w = eff_width(width_reg);
      h = eff_height(height_reg);
      frame = w * h;
      if (phase == 0) begin
        count = 3 * frame;
      end else if (frame > 64 || $urandom_range(0, 6) == 0) begin
        count = $urandom_range(1, 24);
      end else begin
        // finish the frame in progress, then whole frames
        rc = (row_cnt >= h) ? h - 1 : row_cnt;
        cc = (col_cnt >= w) ? w - 1 : col_cnt;
        count = (row_cnt == 0 && col_cnt == 0) ? 0 : (h - 1 - rc) * w + (w - cc);
        count += frame * $urandom_range(1, 2);
      end

      if (phase == 2) begin
        feed_random(count / 2);
        wait_drained();
        feed_random(count - count / 2);
      end else begin
        feed_random(count);
      end
      wait_drained();
      random_items += count;
      phase++;
    end

    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
